/* hdl/mwo_pkg.sv */
// Shared types, constants and tables for the mecanum wheel odometry core.
package mwo_pkg;

    localparam int PosW    = 32;
    localparam int DeltaW  = 33;
    localparam int TSumW   = 35;
    localparam int ScaleW  = 24;
    localparam int ProdW   = TSumW + ScaleW + 1;
    localparam int HeadW   = 19;
    localparam int AngW    = 20;
    localparam int TrigW   = 27;
    localparam int RotW    = DeltaW + TrigW;
    localparam int Steps   = 16;
    localparam int StepW   = 4;
    localparam int QDepth  = 2;
    localparam int QPtrW   = 1;
    localparam int InDataW  = 128;
    localparam int OutDataW = 88;

    localparam logic [ScaleW-1:0] ScaleReset = 24'd65536;
    localparam logic signed [HeadW-1:0] QPi     = 19'sd205887;
    localparam logic signed [AngW-1:0]  QHalfPi = 20'sd102944;
    localparam logic signed [AngW-1:0]  QTwoPi  = 20'sd411775;
    localparam logic signed [TrigW-1:0] CordicGain = 27'sd10187982;

    typedef struct packed {
        logic signed [DeltaW-1:0] dx;
        logic signed [DeltaW-1:0] dy;
        logic signed [TSumW-1:0]  tsum;
    } mwo_entry_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_MUL,
        B_ANG,
        B_CORD,
        B_PA,
        B_PB,
        B_PC
    } mwo_state_t;

    function automatic logic [15:0] atan_q16(input logic [StepW-1:0] i);
        logic [15:0] v;
        case (i)
            4'd0:    v = 16'd51472;
            4'd1:    v = 16'd30386;
            4'd2:    v = 16'd16055;
            4'd3:    v = 16'd8150;
            4'd4:    v = 16'd4091;
            4'd5:    v = 16'd2047;
            4'd6:    v = 16'd1024;
            4'd7:    v = 16'd512;
            4'd8:    v = 16'd256;
            4'd9:    v = 16'd128;
            4'd10:   v = 16'd64;
            4'd11:   v = 16'd32;
            4'd12:   v = 16'd16;
            4'd13:   v = 16'd8;
            4'd14:   v = 16'd4;
            4'd15:   v = 16'd2;
            default: v = 16'd0;
        endcase
        return v;
    endfunction

endpackage

/* hdl/mecanum_wheel_odometry_core.sv */
// Top level of the mecanum wheel odometry core.
//
//  channel   | direction | payload
//  s_axis    | in        | tdata: front_left_pos, front_right_pos, rear_left_pos, rear_right_pos
//  m_axis    | out       | tdata: pose_x, pose_y, heading, clipped
//  cfg       | in        | data: turn_scale
//
// In the pose sequencer each item passes through queue pop, one turn multiply,
// one angle setup, 16 CORDIC iterations, two rotation multiply steps and load.
// A two-entry queue lets the front end take items while the sequencer works.
// The sequencer holds in its last step while the result register is not taken.
// Reset clears wheel history, pose and heading; turn_scale resets to 65536.
module mecanum_wheel_odometry_core (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // front_left_pos[31:0], front_right_pos[63:32], rear_left_pos[95:64],
    // rear_right_pos[127:96]
    input  logic [mwo_pkg::InDataW-1:0]    s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // pose_x[31:0], pose_y[63:32], heading[82:64], clipped[83], zero[87:84]
    output logic [mwo_pkg::OutDataW-1:0]   m_tdata,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [mwo_pkg::ScaleW-1:0]     cfg_data
);

    logic [mwo_pkg::ScaleW-1:0] scale_reg;
    mwo_pkg::mwo_entry_t wr_entry, rd_entry;
    logic full, empty, pop, accept;

    assign cfg_ready = 1'b1;
    assign s_tready  = !full;
    assign accept    = s_tvalid && !full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            scale_reg <= mwo_pkg::ScaleReset;
        else if (cfg_valid)
            scale_reg <= cfg_data;
    end

    mwo_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .data   (s_tdata),
        .entry  (wr_entry)
    );

    mwo_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (accept),
        .wr_entry (wr_entry),
        .pop      (pop),
        .rd_entry (rd_entry),
        .full     (full),
        .empty    (empty)
    );

    mwo_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .turn_scale (scale_reg),
        .entry      (rd_entry),
        .empty      (empty),
        .pop        (pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_data   (m_tdata)
    );

endmodule

/* hdl/mwo_front.sv */
// Front end: wheel deltas against stored travel and body delta sums.
module mwo_front (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         accept,
    input  logic [mwo_pkg::InDataW-1:0]  data,
    output mwo_pkg::mwo_entry_t          entry
);

    logic signed [mwo_pkg::PosW-1:0] last_reg [4];
    logic signed [mwo_pkg::PosW-1:0] pos [4];
    logic signed [mwo_pkg::DeltaW-1:0] d [4];
    logic signed [mwo_pkg::TSumW-1:0] sx, sy;

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            pos[i] = data[i*mwo_pkg::PosW +: mwo_pkg::PosW];
            d[i] = mwo_pkg::DeltaW'(pos[i]) - mwo_pkg::DeltaW'(last_reg[i]);
        end
        sx = mwo_pkg::TSumW'(d[0]) + mwo_pkg::TSumW'(d[1])
           + mwo_pkg::TSumW'(d[2]) + mwo_pkg::TSumW'(d[3]);
        sy = -mwo_pkg::TSumW'(d[0]) + mwo_pkg::TSumW'(d[1])
           + mwo_pkg::TSumW'(d[2]) - mwo_pkg::TSumW'(d[3]);
        entry.tsum = -mwo_pkg::TSumW'(d[0]) + mwo_pkg::TSumW'(d[1])
                   - mwo_pkg::TSumW'(d[2]) + mwo_pkg::TSumW'(d[3]);
        // divide by four, rounding half up
        entry.dx = mwo_pkg::DeltaW'((sx + mwo_pkg::TSumW'(2)) >>> 2);
        entry.dy = mwo_pkg::DeltaW'((sy + mwo_pkg::TSumW'(2)) >>> 2);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++)
                last_reg[i] <= '0;
        end
        else if (accept)
        begin
            for (int i = 0; i < 4; i++)
                last_reg[i] <= pos[i];
        end
    end

endmodule

/* hdl/mwo_queue.sv */
// Two-entry queue between the front end and the pose sequencer.
module mwo_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  mwo_pkg::mwo_entry_t wr_entry,
    input  logic                pop,
    output mwo_pkg::mwo_entry_t rd_entry,
    output logic                full,
    output logic                empty
);

    mwo_pkg::mwo_entry_t q_reg [mwo_pkg::QDepth];
    logic [mwo_pkg::QPtrW-1:0] wr_reg, rd_reg;
    logic [mwo_pkg::QPtrW:0]   cnt_reg;

    assign full     = (cnt_reg == (mwo_pkg::QPtrW+1)'(mwo_pkg::QDepth));
    assign empty    = (cnt_reg == '0);
    assign rd_entry = q_reg[rd_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            q_reg[wr_reg] <= wr_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wr_reg <= wr_reg + 1'b1;
            if (pop)
                rd_reg <= rd_reg + 1'b1;
            if (push && !pop)
                cnt_reg <= cnt_reg + 1'b1;
            else if (pop && !push)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

endmodule

/* hdl/mwo_back.sv */
// Pose sequencer: turn scaling, CORDIC sine/cosine, rotation and accumulation.
module mwo_back (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [mwo_pkg::ScaleW-1:0]     turn_scale,
    input  mwo_pkg::mwo_entry_t            entry,
    input  logic                           empty,
    output logic                           pop,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [mwo_pkg::OutDataW-1:0]   out_data
);

    mwo_pkg::mwo_state_t state_reg, state_next;

    mwo_pkg::mwo_entry_t ent_reg;
    logic signed [mwo_pkg::ProdW-1:0]  prod_reg;
    logic signed [mwo_pkg::HeadW-1:0]  dth_reg;
    logic                              flip_reg;
    logic                              clip_reg;
    logic signed [mwo_pkg::TrigW-1:0]  x_reg, y_reg;
    logic signed [mwo_pkg::AngW-1:0]   z_reg;
    logic [mwo_pkg::StepW-1:0]         cnt_reg;
    logic signed [mwo_pkg::RotW-1:0]   pa_reg, pb_reg;
    logic signed [mwo_pkg::PosW-1:0]   px_reg, py_reg;
    logic signed [mwo_pkg::HeadW-1:0]  head_reg;
    logic                              ovalid_reg;
    logic [mwo_pkg::OutDataW-1:0]      odata_reg;

    logic load, out_load, cord_last;

    logic signed [mwo_pkg::ProdW-1:0]  dth_full;
    logic signed [mwo_pkg::HeadW-1:0]  dth_sat;
    logic                              dth_clip;
    logic signed [mwo_pkg::AngW-1:0]   half, avg, zin;
    logic                              flip;
    logic signed [mwo_pkg::TrigW-1:0]  xs, ys, c, s;
    logic signed [mwo_pkg::AngW-1:0]   at;
    logic signed [mwo_pkg::RotW:0]     rsum;
    logic signed [mwo_pkg::RotW:0]     g;
    logic signed [mwo_pkg::RotW:0]     acc;
    logic signed [mwo_pkg::PosW-1:0]   acc_sat;
    logic                              acc_clip;
    logic signed [mwo_pkg::AngW-1:0]   h;
    logic signed [mwo_pkg::HeadW-1:0]  h_wrap;

    assign cord_last = (cnt_reg == mwo_pkg::StepW'(mwo_pkg::Steps - 1));
    assign out_valid = ovalid_reg;
    assign out_data  = odata_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            mwo_pkg::B_IDLE: if (!empty) state_next = mwo_pkg::B_MUL;
            mwo_pkg::B_MUL:  state_next = mwo_pkg::B_ANG;
            mwo_pkg::B_ANG:  state_next = mwo_pkg::B_CORD;
            mwo_pkg::B_CORD: if (cord_last) state_next = mwo_pkg::B_PA;
            mwo_pkg::B_PA:   state_next = mwo_pkg::B_PB;
            mwo_pkg::B_PB:   state_next = mwo_pkg::B_PC;
            mwo_pkg::B_PC:   if (!ovalid_reg || out_ready) state_next = mwo_pkg::B_IDLE;
            default:         state_next = mwo_pkg::B_IDLE;
        endcase
    end

    // control outputs
    always_comb
    begin
        load     = 1'b0;
        out_load = 1'b0;
        case (state_reg)
            mwo_pkg::B_IDLE: load = !empty;
            mwo_pkg::B_PC:   out_load = !ovalid_reg || out_ready;
            default:
            begin
                load     = 1'b0;
                out_load = 1'b0;
            end
        endcase
    end
    assign pop = load;

    // datapath
    always_comb
    begin
        dth_full = (prod_reg + mwo_pkg::ProdW'(32768)) >>> 16;
        dth_clip = 1'b1;
        if (dth_full > mwo_pkg::ProdW'(mwo_pkg::QPi))
            dth_sat = mwo_pkg::QPi;
        else if (dth_full < -mwo_pkg::ProdW'(mwo_pkg::QPi))
            dth_sat = -mwo_pkg::QPi;
        else
        begin
            dth_sat  = mwo_pkg::HeadW'(dth_full);
            dth_clip = 1'b0;
        end
        half = mwo_pkg::AngW'((mwo_pkg::AngW'(dth_sat) + mwo_pkg::AngW'(1)) >>> 1);
        avg  = mwo_pkg::AngW'(head_reg) + half;
        flip = 1'b1;
        if (avg > mwo_pkg::QHalfPi)
            zin = avg - mwo_pkg::AngW'(mwo_pkg::QPi);
        else if (avg < -mwo_pkg::QHalfPi)
            zin = avg + mwo_pkg::AngW'(mwo_pkg::QPi);
        else
        begin
            zin  = avg;
            flip = 1'b0;
        end

        xs = x_reg >>> cnt_reg;
        ys = y_reg >>> cnt_reg;
        at = mwo_pkg::AngW'({1'b0, mwo_pkg::atan_q16(cnt_reg)});
        c  = flip_reg ? -x_reg : x_reg;
        s  = flip_reg ? -y_reg : y_reg;

        rsum = (state_reg == mwo_pkg::B_PB)
             ? (mwo_pkg::RotW+1)'(pa_reg) - (mwo_pkg::RotW+1)'(pb_reg)
             : (mwo_pkg::RotW+1)'(pa_reg) + (mwo_pkg::RotW+1)'(pb_reg);
        g   = (rsum + (mwo_pkg::RotW+1)'(8388608)) >>> 24;
        acc = g + (mwo_pkg::RotW+1)'((state_reg == mwo_pkg::B_PB) ? px_reg : py_reg);
        acc_clip = 1'b1;
        if (acc > (mwo_pkg::RotW+1)'(32'sh7FFFFFFF))
            acc_sat = 32'sh7FFFFFFF;
        else if (acc < -(mwo_pkg::RotW+1)'(33'sh080000000))
            acc_sat = 32'sh80000000;
        else
        begin
            acc_sat  = mwo_pkg::PosW'(acc);
            acc_clip = 1'b0;
        end

        h = mwo_pkg::AngW'(head_reg) + mwo_pkg::AngW'(dth_reg);
        if (h > mwo_pkg::AngW'(mwo_pkg::QPi))
            h_wrap = mwo_pkg::HeadW'(h - mwo_pkg::QTwoPi);
        else if (h < -mwo_pkg::AngW'(mwo_pkg::QPi))
            h_wrap = mwo_pkg::HeadW'(h + mwo_pkg::QTwoPi);
        else
            h_wrap = mwo_pkg::HeadW'(h);
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            mwo_pkg::B_IDLE:
                if (load)
                    ent_reg <= entry;
            mwo_pkg::B_MUL:
                prod_reg <= mwo_pkg::ProdW'(ent_reg.tsum)
                          * mwo_pkg::ProdW'($signed({1'b0, turn_scale}));
            mwo_pkg::B_ANG:
            begin
                dth_reg  <= dth_sat;
                flip_reg <= flip;
                x_reg    <= mwo_pkg::CordicGain;
                y_reg    <= '0;
                z_reg    <= zin;
            end
            mwo_pkg::B_CORD:
            begin
                if (z_reg >= 0)
                begin
                    x_reg <= x_reg - ys;
                    y_reg <= y_reg + xs;
                    z_reg <= z_reg - at;
                end
                else
                begin
                    x_reg <= x_reg + ys;
                    y_reg <= y_reg - xs;
                    z_reg <= z_reg + at;
                end
            end
            mwo_pkg::B_PA:
            begin
                pa_reg <= mwo_pkg::RotW'(ent_reg.dx) * mwo_pkg::RotW'(c);
                pb_reg <= mwo_pkg::RotW'(ent_reg.dy) * mwo_pkg::RotW'(s);
            end
            mwo_pkg::B_PB:
            begin
                pa_reg <= mwo_pkg::RotW'(ent_reg.dx) * mwo_pkg::RotW'(s);
                pb_reg <= mwo_pkg::RotW'(ent_reg.dy) * mwo_pkg::RotW'(c);
            end
            default:
                pa_reg <= pa_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= mwo_pkg::B_IDLE;
            cnt_reg    <= '0;
            clip_reg   <= 1'b0;
            px_reg     <= '0;
            py_reg     <= '0;
            head_reg   <= '0;
            ovalid_reg <= 1'b0;
            odata_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == mwo_pkg::B_CORD)
                cnt_reg <= cnt_reg + 1'b1;
            if (state_reg == mwo_pkg::B_ANG)
                clip_reg <= dth_clip;
            if (state_reg == mwo_pkg::B_PB)
            begin
                px_reg <= acc_sat;
                clip_reg <= clip_reg | acc_clip;
            end
            if (out_load)
            begin
                py_reg     <= acc_sat;
                head_reg   <= h_wrap;
                ovalid_reg <= 1'b1;
                odata_reg  <= {4'b0, clip_reg | acc_clip, h_wrap, acc_sat, px_reg};
            end
            else if (out_ready)
                ovalid_reg <= 1'b0;
        end
    end

endmodule

/* hdl/mwo_checker.sv */
// Port-level checks for the odometry core, bound to the top level.
module mwo_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [mwo_pkg::OutDataW-1:0]  m_tdata,
    input logic                          cfg_ready
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_head: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ($signed(m_tdata[82:64]) <= 19'sd205887)
                  && ($signed(m_tdata[82:64]) >= -19'sd205887))
        else $error("heading out of range");

    a_pad: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[87:84] == 4'b0)
        else $error("padding bits set");

    a_cfg: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready)
        else $error("config port not ready");

    // the queue only fills on an input transfer
    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(s_tready) |-> $past(s_tvalid && s_tready))
        else $error("input stalled without a transfer");

endmodule

bind mecanum_wheel_odometry_core mwo_checker u_mwo_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_ready (cfg_ready)
);

/* sim/testbench.sv */
// Self-checking testbench for the mecanum wheel odometry core.
`timescale 1ns / 1ps

typedef struct packed {
    logic [3:0]         pad;
    logic               clipped;
    logic signed [18:0] heading;
    logic signed [31:0] pose_y;
    logic signed [31:0] pose_x;
} pose_t;

class pose_scoreboard;
    longint wheel_hist[4];
    longint px;
    longint py;
    longint hacc;
    longint scale;
    pose_t  pending[$];
    int     errors;

    function new();
        int k;
        for (k = 0; k < 4; k++)
            wheel_hist[k] = 0;
        px = 0;
        py = 0;
        hacc = 0;
        scale = 65536;
        errors = 0;
    endfunction

    function longint rshr(longint v, int s);
        return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function void note_wheels(logic [127:0] data);
        longint d[4];
        longint dx, dy, dth, ang, cx, sy, z, xs, ys, gx, gy, h;
        longint atan_tab[16];
        bit clip, flip;
        int k;
        pose_t r;
        atan_tab = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                     256, 128, 64, 32, 16, 8, 4, 2};
        clip = 0;
        for (k = 0; k < 4; k++)
        begin
            longint p;
            p = longint'($signed(data[32*k +: 32]));
            d[k] = p - wheel_hist[k];
            wheel_hist[k] = p;
        end
        dx = rshr(d[0] + d[1] + d[2] + d[3], 2);
        dy = rshr(-d[0] + d[1] + d[2] - d[3], 2);
        dth = rshr((-d[0] + d[1] - d[2] + d[3]) * scale, 16);
        if (dth > 205887)
        begin
            dth = 205887;
            clip = 1;
        end
        else if (dth < -205887)
        begin
            dth = -205887;
            clip = 1;
        end
        ang = hacc + rshr(dth, 1);
        cx = 10187982;
        sy = 0;
        z = ang;
        flip = 0;
        if (z > 102944)
        begin
            z -= 205887;
            flip = 1;
        end
        else if (z < -102944)
        begin
            z += 205887;
            flip = 1;
        end
        for (k = 0; k < 16; k++)
        begin
            xs = cx >>> k;
            ys = sy >>> k;
            if (z >= 0)
            begin
                cx -= ys;
                sy += xs;
                z -= atan_tab[k];
            end
            else
            begin
                cx += ys;
                sy -= xs;
                z += atan_tab[k];
            end
        end
        if (flip)
        begin
            cx = -cx;
            sy = -sy;
        end
        gx = rshr(dx * cx - dy * sy, 24);
        gy = rshr(dx * sy + dy * cx, 24);
        px += gx;
        py += gy;
        if (px > 64'sd2147483647) begin px = 64'sd2147483647; clip = 1; end
        if (px < -64'sd2147483648) begin px = -64'sd2147483648; clip = 1; end
        if (py > 64'sd2147483647) begin py = 64'sd2147483647; clip = 1; end
        if (py < -64'sd2147483648) begin py = -64'sd2147483648; clip = 1; end
        h = hacc + dth;
        if (h > 205887)
            h -= 411775;
        else if (h < -205887)
            h += 411775;
        hacc = h;
        r.pad = '0;
        r.pose_x = px[31:0];
        r.pose_y = py[31:0];
        r.heading = hacc[18:0];
        r.clipped = clip;
        pending.push_back(r);
    endfunction

    function void check_pose(logic [87:0] data);
        pose_t got, want;
        got = data;
        if (pending.size() == 0)
        begin
            errors++;
            if (errors <= 10)
                $display("unexpected pose transfer %h", data);
            return;
        end
        want = pending.pop_front();
        if (got !== want)
        begin
            errors++;
            if (errors <= 10)
                $display("pose mismatch: exp x=%0d y=%0d h=%0d c=%0d got x=%0d y=%0d h=%0d c=%0d",
                         want.pose_x, want.pose_y, want.heading, want.clipped,
                         got.pose_x, got.pose_y, got.heading, got.clipped);
        end
    endfunction
endclass

module testbench;

    logic                         clk;
    logic                         rst_n;
    logic                         s_tvalid;
    logic                         s_tready;
    logic [mwo_pkg::InDataW-1:0]  s_tdata;
    logic                         m_tvalid;
    logic                         m_tready;
    logic [mwo_pkg::OutDataW-1:0] m_tdata;
    logic                         cfg_valid;
    logic                         cfg_ready;
    logic [mwo_pkg::ScaleW-1:0]   cfg_data;

    pose_scoreboard board;
    int  send_idle_pct;
    int  recv_stall_pct;
    bit  hold_off;
    longint cycles;
    logic [31:0] wheel[4];

    mecanum_wheel_odometry_core dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // receiver side: random stall, long hold-off on request
    always @(negedge clk)
        m_tready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);

    always @(posedge clk)
        if (rst_n && m_tvalid && m_tready)
            board.check_pose(m_tdata);

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > 3000000)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // valid stays high after a transfer; stop_send drops it, the next call only for a random idle gap
    task automatic send_wheels(logic [31:0] fl, logic [31:0] fr,
                               logic [31:0] rl, logic [31:0] rr);
        if ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
            while ($urandom_range(99) < send_idle_pct)
                @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {rr, rl, fr, fl};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        board.note_wheels({rr, rl, fr, fl});
        @(negedge clk);
    endtask

    task automatic stop_send();
        s_tvalid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic write_scale(logic [23:0] v);
        stop_send();
        // let the sequencer drain before touching the register
        while (board.pending.size() != 0)
            @(negedge clk);
        repeat (40) @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        board.scale = v;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // step relative to the last travel, small moves mostly
    task automatic random_move(int span);
        int k;
        logic [31:0] nw[4];
        for (k = 0; k < 4; k++)
        begin
            if ($urandom_range(19) == 0)
                nw[k] = $urandom;
            else
                nw[k] = wheel[k] + $signed($urandom_range(2 * span) - span);
            wheel[k] = nw[k];
        end
        send_wheels(nw[0], nw[1], nw[2], nw[3]);
    endtask

    initial
    begin
        int n, ph;
        logic [23:0] scales[5];
        board = new();
        cycles = 0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        hold_off = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        m_tready = 1'b0;
        for (n = 0; n < 4; n++)
            wheel[n] = '0;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: first item against zero, extremes, big turns, wraps
        send_wheels(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
        send_wheels(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
        send_wheels(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_wheels(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
        send_wheels(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
        send_wheels(32'hffff_ffff, 32'h0, 32'hffff_ffff, 32'h0);
        for (n = 0; n < 6; n++)
            send_wheels(32'h0, 32'h0001_8000 * (n + 1), 32'h0, 32'h0001_8000 * (n + 1));
        for (n = 0; n < 6; n++)
            send_wheels(32'h4000_0000, 32'h4000_0000 + n * 32'h0100_0000,
                        32'h4000_0000, 32'h4000_0000 + n * 32'h0100_0000);
        for (n = 0; n < 4; n++)
            wheel[n] = 32'h4000_0000 + ((n % 2) ? 5 * 32'h0100_0000 : 0);

        scales = '{24'd0, 24'hffffff, 24'd13107, 24'd65536, 24'd200000};
        for (ph = 0; ph < 5; ph++)
        begin
            write_scale(scales[ph]);
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 63; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 63; end
                default: begin send_idle_pct = 21; recv_stall_pct = 21; end
            endcase
            if (ph == 2)
            begin
                fork
                    begin
                        hold_off = 1'b1;
                        repeat (300) @(negedge clk);
                        hold_off = 1'b0;
                    end
                    for (n = 0; n < 10; n++)
                        random_move(32'h0004_0000);
                join
            end
            for (n = 0; n < 365; n++)
                random_move((n % 3 == 0) ? 32'h0100_0000 : 32'h0002_0000);
        end

        stop_send();
        while (board.pending.size() != 0)
            @(negedge clk);
        repeat (60) @(negedge clk);
        if (board.errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
